>>> sv/separable_2d_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// separable 2-d filter unit assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_2D_FILTER_UNIT_MACROS_SVH
`define SEPARABLE_2D_FILTER_UNIT_MACROS_SVH

`ifndef SYNTH
// condition must never hold
`define SF2D_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sf2d check failed");
// pre in one cycle implies post in the next
`define SF2D_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sf2d check failed");
`else
`define SF2D_ASSERT_NEVER(lbl, cond)
`define SF2D_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> sv/sf2d_pkg.sv
// ----------------------------------------------------------------------------
// sf2d_pkg
// shared constants, types and coefficient helpers of the separable filter
// ----------------------------------------------------------------------------
package sf2d_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_TAPS_DEF   = 10;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 12;
  localparam int MID_W        = 20;
  localparam int RES_W        = 24;
  localparam int FRAC_W       = 10;
  localparam int NUM_COEF     = 10;
  localparam int COEF_PER_REG = 5;
  localparam int COEF_REG_W   = 60;
  localparam int FW_W         = 11;
  localparam int TAPCFG_W     = 4;

  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  localparam int FIFO_DEPTH = 9;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_ROW_TAPS    = 3'd1,
    REG_COL_TAPS    = 3'd2,
    REG_ACCUMULATE  = 3'd3,
    REG_ROW_LO      = 3'd4,
    REG_ROW_HI      = 3'd5,
    REG_COL_LO      = 3'd6,
    REG_COL_HI      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  // coefficient idx out of a lo/hi register pair, zero beyond the stored set
  function automatic logic signed [COEF_W-1:0] get_coef(
    input logic [COEF_REG_W-1:0] lo,
    input logic [COEF_REG_W-1:0] hi,
    input int unsigned           idx
  );
    logic [COEF_REG_W-1:0] src;
    int unsigned           pos;
    if (idx >= NUM_COEF) begin
      return '0;
    end
    src = (idx < COEF_PER_REG) ? lo : hi;
    pos = ((idx < COEF_PER_REG) ? idx : idx - COEF_PER_REG) * COEF_W;
    return $signed(src[pos +: COEF_W]);
  endfunction

endpackage

>>> sv/separable_2d_filter_unit.sv
// ----------------------------------------------------------------------------
// separable_2d_filter_unit
// streaming separable 2-d fir filter, valid output positions only
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i/in_ready_o) takes one raster sample per item in
//   row order with frame_start_i on the first sample of a frame and the prior
//   destination value. every item gives exactly one result item on the output
//   channel (res_valid_o/res_ready_i); out_valid_o flags a valid position.
//   results pass the pipeline registers and the queue before being offered.
//   throughput is one item per cycle: the pipeline runs every cycle and a
//   9-entry result queue absorbs it, ready drops only when 9 items are
//   accepted but not yet taken. the line stores are one ram per earlier
//   tap row; each horizontally valid item reads and writes its output column.
//   reset clears position counters, the row window and config registers to
//   their defaults (width 1024, one tap each, unity coefficients). the line
//   stores are not cleared and need no clearing pass.
//   when the receiver stalls, results wait in the queue and input keeps
//   flowing until the queue budget is used up.
//   configuration is an apb port with 64-bit registers at byte address 8*i;
//   write it only while the block is idle.
// ----------------------------------------------------------------------------
`include "separable_2d_filter_unit_macros.svh"

module separable_2d_filter_unit #(
  parameter int unsigned MAX_WIDTH  = sf2d_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_TAPS   = sf2d_pkg::MAX_TAPS_DEF,
  parameter int unsigned MAX_HEIGHT = sf2d_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sf2d_pkg::APB_AW-1:0]         paddr,
  input  logic [sf2d_pkg::APB_DW-1:0]         pwdata,
  output logic [sf2d_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sf2d_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                frame_start_i,
  input  logic signed [sf2d_pkg::RES_W-1:0]   prior_value_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic signed [sf2d_pkg::RES_W-1:0]   filtered_value_o,
  output logic                                out_valid_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]       out_row_o
);
  import sf2d_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HIST   = MAX_TAPS - 1;
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int TC_W   = (TAP_W > TAPCFG_W) ? TAP_W : TAPCFG_W;
  localparam int WC_W   = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
  localparam int LOG_T  = $clog2(MAX_TAPS) + 1;
  localparam int HP_W   = SAMPLE_W + COEF_W;
  localparam int HSUM_W = HP_W + LOG_T;
  localparam int VP_W   = MID_W + COEF_W;
  localparam int VSUM_W = VP_W + LOG_T;
  localparam int PACK_W = RES_W + 1 + COL_W + ROW_W;

  localparam logic signed [HSUM_W-1:0] H_RND    = HSUM_W'(1 << (FRAC_W - 1));
  localparam logic signed [HSUM_W-1:0] H_SAT_HI = HSUM_W'((1 << (MID_W - 1)) - 1);
  localparam logic signed [HSUM_W-1:0] H_SAT_LO = -H_SAT_HI - HSUM_W'(1);
  localparam logic signed [VSUM_W-1:0] V_RND    = VSUM_W'(1 << (FRAC_W - 1));
  localparam logic signed [VSUM_W-1:0] V_SAT_HI = VSUM_W'((1 << (RES_W - 1)) - 1);
  localparam logic signed [VSUM_W-1:0] V_SAT_LO = -V_SAT_HI - VSUM_W'(1);
  localparam logic signed [RES_W:0]    A_SAT_HI = (RES_W + 1)'((1 << (RES_W - 1)) - 1);
  localparam logic signed [RES_W:0]    A_SAT_LO = -A_SAT_HI - (RES_W + 1)'(1);

  // configuration registers
  logic [FW_W-1:0]       frame_width_q;
  logic [TAPCFG_W-1:0]   row_taps_q, col_taps_q;
  logic                  accumulate_q;
  logic [COEF_REG_W-1:0] row_lo_q, row_hi_q, col_lo_q, col_hi_q;
  reg_idx_e              reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FW_W'(MAX_WIDTH_DEF);
      row_taps_q    <= TAPCFG_W'(1);
      col_taps_q    <= TAPCFG_W'(1);
      accumulate_q  <= 1'b0;
      row_lo_q      <= COEF_REG_W'(1 << FRAC_W);
      row_hi_q      <= '0;
      col_lo_q      <= COEF_REG_W'(1 << FRAC_W);
      col_hi_q      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH: frame_width_q <= pwdata[FW_W-1:0];
        REG_ROW_TAPS:    row_taps_q    <= pwdata[TAPCFG_W-1:0];
        REG_COL_TAPS:    col_taps_q    <= pwdata[TAPCFG_W-1:0];
        REG_ACCUMULATE:  accumulate_q  <= pwdata[0];
        REG_ROW_LO:      row_lo_q      <= pwdata[COEF_REG_W-1:0];
        REG_ROW_HI:      row_hi_q      <= pwdata[COEF_REG_W-1:0];
        REG_COL_LO:      col_lo_q      <= pwdata[COEF_REG_W-1:0];
        REG_COL_HI:      col_hi_q      <= pwdata[COEF_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH: prdata = APB_DW'(frame_width_q);
      REG_ROW_TAPS:    prdata = APB_DW'(row_taps_q);
      REG_COL_TAPS:    prdata = APB_DW'(col_taps_q);
      REG_ACCUMULATE:  prdata = APB_DW'(accumulate_q);
      REG_ROW_LO:      prdata = APB_DW'(row_lo_q);
      REG_ROW_HI:      prdata = APB_DW'(row_hi_q);
      REG_COL_LO:      prdata = APB_DW'(col_lo_q);
      REG_COL_HI:      prdata = APB_DW'(col_hi_q);
      default:         prdata = '0;
    endcase
  end

  // clamped counts
  logic [TC_W-1:0]  rt_ext, ct_ext;
  logic [TAP_W-1:0] rt, ct;
  logic [WC_W-1:0]  fw_ext, width;

  always_comb begin
    rt_ext = TC_W'(row_taps_q);
    ct_ext = TC_W'(col_taps_q);
    fw_ext = WC_W'(frame_width_q);
    if (rt_ext == '0) begin
      rt = TAP_W'(1);
    end else if (rt_ext > TC_W'(MAX_TAPS)) begin
      rt = TAP_W'(MAX_TAPS);
    end else begin
      rt = rt_ext[TAP_W-1:0];
    end
    if (ct_ext == '0) begin
      ct = TAP_W'(1);
    end else if (ct_ext > TC_W'(MAX_TAPS)) begin
      ct = TAP_W'(MAX_TAPS);
    end else begin
      ct = ct_ext[TAP_W-1:0];
    end
    if (fw_ext == '0) begin
      width = WC_W'(1);
    end else if (fw_ext > WC_W'(MAX_WIDTH)) begin
      width = WC_W'(MAX_WIDTH);
    end else begin
      width = fw_ext;
    end
  end

  // occupancy budget for the result queue
  logic                  accept, pop;
  logic [FIFO_CNT_W-1:0] occ_q, occ_d;
  fifo_stat_t            fifo_stat;

  assign in_ready_o = (occ_q < FIFO_CNT_W'(FIFO_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign res_valid_o = !fifo_stat.empty;
  assign pop        = res_valid_o && res_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (accept && !pop) begin
      occ_d = occ_q + 1'b1;
    end else if (!accept && pop) begin
      occ_d = occ_q - 1'b1;
    end
  end

  // position tracking
  logic [COL_W-1:0] col_q, col_d, cur_col, oc_in;
  logic [ROW_W-1:0] row_q, row_d, cur_row, orow_in;
  logic [COL_W:0]   col_p1;
  logic [ROW_W:0]   row_p1;
  logic             hv_in, pv_in;

  always_comb begin
    cur_col = frame_start_i ? '0 : col_q;
    cur_row = frame_start_i ? '0 : row_q;
    col_p1  = {1'b0, cur_col} + 1'b1;
    row_p1  = {1'b0, cur_row} + 1'b1;
    hv_in   = col_p1 >= (COL_W + 1)'(rt);
    pv_in   = hv_in && (row_p1 >= (ROW_W + 1)'(ct));
    oc_in   = COL_W'(col_p1 - (COL_W + 1)'(rt));
    orow_in = ROW_W'(row_p1 - (ROW_W + 1)'(ct));
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (WC_W'(col_p1) >= width) begin
        col_d = '0;
        row_d = (cur_row < ROW_W'(MAX_HEIGHT - 1)) ? ROW_W'(cur_row + 1'b1) : cur_row;
      end else begin
        col_d = col_p1[COL_W-1:0];
        row_d = cur_row;
      end
    end
  end

  // row window of earlier samples, newest first
  logic signed [SAMPLE_W-1:0] rw_q [HIST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST; k++) begin
        rw_q[k] <= '0;
      end
    end else if (accept) begin
      rw_q[0] <= sample_i;
      for (int k = 1; k < HIST; k++) begin
        rw_q[k] <= rw_q[k-1];
      end
    end
  end

  // coefficients laid out per tap line position, reversed by tap count
  logic signed [COEF_W-1:0] hc_d [MAX_TAPS];
  logic signed [COEF_W-1:0] vc_d [MAX_TAPS];
  logic signed [COEF_W-1:0] hc_q [MAX_TAPS];
  logic signed [COEF_W-1:0] vc_q [MAX_TAPS];

  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      hc_d[j] = (j < int'(rt)) ?
        get_coef(row_lo_q, row_hi_q, unsigned'(int'(rt) - 1 - j)) : '0;
      vc_d[j] = (j < int'(ct)) ?
        get_coef(col_lo_q, col_hi_q, unsigned'(int'(ct) - 1 - j)) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    hc_q <= hc_d;
    vc_q <= vc_d;
  end

  // pipeline valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic hv1_q, hv2_q, hv3_q, hv4_q;
  logic pv1_q, pv2_q, pv3_q, pv4_q, pv5_q, pv6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      hv1_q <= 1'b0;
      hv2_q <= 1'b0;
      hv3_q <= 1'b0;
      hv4_q <= 1'b0;
      pv1_q <= 1'b0;
      pv2_q <= 1'b0;
      pv3_q <= 1'b0;
      pv4_q <= 1'b0;
      pv5_q <= 1'b0;
      pv6_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= accept;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      hv1_q <= accept && hv_in;
      hv2_q <= hv1_q;
      hv3_q <= hv2_q;
      hv4_q <= hv3_q;
      pv1_q <= accept && pv_in;
      pv2_q <= pv1_q;
      pv3_q <= pv2_q;
      pv4_q <= pv3_q;
      pv5_q <= pv4_q;
      pv6_q <= pv5_q;
    end
  end

  // payload stages
  logic signed [SAMPLE_W-1:0] d1_q [MAX_TAPS];
  logic signed [HP_W-1:0]     hp2_q [MAX_TAPS];
  logic signed [MID_W-1:0]    h3_q, h4_q;
  logic signed [MID_W-1:0]    y4_q [HIST];
  logic signed [VP_W-1:0]     vp5_q [MAX_TAPS];
  logic signed [RES_W-1:0]    r6_q;
  logic [COL_W-1:0]           oc1_q, oc2_q, oc3_q, oc4_q, oc5_q, oc6_q;
  logic [ROW_W-1:0]           or1_q, or2_q, or3_q, or4_q, or5_q, or6_q;
  logic signed [RES_W-1:0]    pr1_q, pr2_q, pr3_q, pr4_q, pr5_q, pr6_q;

  // horizontal pass
  logic signed [HSUM_W-1:0] hsum, hsh;
  logic signed [MID_W-1:0]  h3_d;

  always_comb begin
    hsum = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      hsum = hsum + HSUM_W'(hp2_q[j]);
    end
    hsh = (hsum + H_RND) >>> FRAC_W;
    if (hsh > H_SAT_HI) begin
      h3_d = MID_W'(H_SAT_HI);
    end else if (hsh < H_SAT_LO) begin
      h3_d = MID_W'(H_SAT_LO);
    end else begin
      h3_d = MID_W'(hsh);
    end
  end

  // line stores: chain k holds the intermediate from k+1 rows back
  logic [MID_W-1:0]        rdata [HIST];
  logic [MID_W-1:0]        wdata [HIST];
  logic signed [MID_W-1:0] eff [HIST];
  logic                    fwd;

  // back-to-back items on the same column see the write still in flight
  assign fwd = v4_q && hv4_q && v3_q && hv3_q && (oc4_q == oc3_q);

  always_comb begin
    for (int k = 0; k < HIST; k++) begin
      if (fwd) begin
        eff[k] = (k == 0) ? h4_q : y4_q[(k == 0) ? 0 : k - 1];
      end else begin
        eff[k] = $signed(rdata[k]);
      end
    end
    wdata[0] = h3_q;
    for (int k = 1; k < HIST; k++) begin
      wdata[k] = eff[k-1];
    end
  end

  for (genvar k = 0; k < HIST; k++) begin : g_line
    sf2d_ram #(
      .WIDTH(MID_W),
      .DEPTH(MAX_WIDTH)
    ) u_line_ram (
      .clk_i  (clk_i),
      .we_i   (v3_q && hv3_q),
      .waddr_i(oc3_q),
      .wdata_i(wdata[k]),
      .re_i   (v2_q && hv2_q),
      .raddr_i(oc2_q),
      .rdata_o(rdata[k])
    );
  end

  // vertical pass
  logic signed [VSUM_W-1:0] vsum, vsh;
  logic signed [RES_W-1:0]  r6_d;

  always_comb begin
    vsum = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      vsum = vsum + VSUM_W'(vp5_q[j]);
    end
    vsh = (vsum + V_RND) >>> FRAC_W;
    if (vsh > V_SAT_HI) begin
      r6_d = RES_W'(V_SAT_HI);
    end else if (vsh < V_SAT_LO) begin
      r6_d = RES_W'(V_SAT_LO);
    end else begin
      r6_d = RES_W'(vsh);
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q[0] <= sample_i;
    for (int j = 1; j < MAX_TAPS; j++) begin
      d1_q[j] <= rw_q[j-1];
    end
    oc1_q <= oc_in;
    or1_q <= orow_in;
    pr1_q <= prior_value_i;

    for (int j = 0; j < MAX_TAPS; j++) begin
      hp2_q[j] <= hc_q[j] * d1_q[j];
    end
    oc2_q <= oc1_q;
    or2_q <= or1_q;
    pr2_q <= pr1_q;

    h3_q  <= h3_d;
    oc3_q <= oc2_q;
    or3_q <= or2_q;
    pr3_q <= pr2_q;

    h4_q  <= h3_q;
    y4_q  <= eff;
    oc4_q <= oc3_q;
    or4_q <= or3_q;
    pr4_q <= pr3_q;

    vp5_q[0] <= vc_q[0] * h4_q;
    for (int j = 1; j < MAX_TAPS; j++) begin
      vp5_q[j] <= vc_q[j] * y4_q[j-1];
    end
    oc5_q <= oc4_q;
    or5_q <= or4_q;
    pr5_q <= pr4_q;

    r6_q  <= r6_d;
    oc6_q <= oc5_q;
    or6_q <= or5_q;
    pr6_q <= pr5_q;
  end

  // accumulate and pack
  logic signed [RES_W:0]   asum;
  logic signed [RES_W-1:0] res_val;
  logic [PACK_W-1:0]       push_data, head_data;

  always_comb begin
    asum = (RES_W + 1)'(r6_q) + (RES_W + 1)'(pr6_q);
    if (!pv6_q) begin
      res_val = '0;
    end else if (!accumulate_q) begin
      res_val = r6_q;
    end else if (asum > A_SAT_HI) begin
      res_val = RES_W'(A_SAT_HI);
    end else if (asum < A_SAT_LO) begin
      res_val = RES_W'(A_SAT_LO);
    end else begin
      res_val = RES_W'(asum);
    end
    push_data = {res_val, pv6_q, pv6_q ? oc6_q : COL_W'(0), pv6_q ? or6_q : ROW_W'(0)};
  end

  sf2d_fifo #(
    .DW(PACK_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (v6_q),
    .wdata_i(push_data),
    .pop_i  (pop),
    .rdata_o(head_data),
    .stat_o (fifo_stat)
  );

  assign filtered_value_o = $signed(head_data[PACK_W-1 -: RES_W]);
  assign out_valid_o      = head_data[COL_W + ROW_W];
  assign out_col_o        = head_data[ROW_W +: COL_W];
  assign out_row_o        = head_data[ROW_W-1:0];

  `SF2D_ASSERT_NEXT(a_accept_enters_pipe, in_valid_i && in_ready_o, v1_q)
  `SF2D_ASSERT_NEVER(a_queue_within_budget, fifo_stat.count > occ_q)
  `SF2D_ASSERT_NEVER(a_no_push_when_full, v6_q && fifo_stat.full && !pop)

endmodule

>>> sv/sf2d_ram.sv
// ----------------------------------------------------------------------------
// sf2d_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sf2d_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read during write to the same address returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> sv/sf2d_fifo.sv
// ----------------------------------------------------------------------------
// sf2d_fifo
// small result queue between the filter pipeline and the output channel
// ----------------------------------------------------------------------------
module sf2d_fifo #(
  parameter int DW = 47
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [DW-1:0]          wdata_i,
  input  logic                   pop_i,
  output logic [DW-1:0]          rdata_o,
  output sf2d_pkg::fifo_stat_t   stat_o
);
  import sf2d_pkg::*;

  logic [DW-1:0]         mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign do_push = push_i && (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.count = cnt_q;

endmodule
